>>> rtl/prefix_bitmap_key_matcher_defines.svh
// Assertion macros used by the checker file of the key matcher.
`ifndef PREFIX_BITMAP_KEY_MATCHER_DEFINES_SVH
`define PREFIX_BITMAP_KEY_MATCHER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PBKM_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pbkm: same-cycle check failed");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PBKM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pbkm: next-cycle check failed");

`endif

>>> rtl/pbkm_pkg.sv
package pbkm_pkg;

  // Default sizes of the name table.
  localparam int unsigned ENTRY_SLOTS_DEF  = 8;
  localparam int unsigned MAX_NAME_LEN_DEF = 64;

  // Fixed widths of the item fields and of the position counters.
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned FIELD_W = 16;
  localparam int unsigned STAT_W  = 2;
  localparam int unsigned POS_W   = 7;
  localparam logic [POS_W-1:0] POS_LIMIT = 7'd127;

  // Item kinds.
  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_QUERY = 1'b1
  } action_e;

  // Result status codes.
  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_MISS     = 2'd1,
    ST_FULL     = 2'd2,
    ST_TOO_LONG = 2'd3
  } status_e;

  // Controller states.
  typedef enum logic {
    CS_IDLE    = 1'b0,
    CS_COMPARE = 1'b1
  } ctrl_state_e;

  // Input item.
  typedef struct packed {
    logic               action;
    logic [BYTE_W-1:0]  key_byte;
    logic               last;
    logic [FIELD_W-1:0] field_number;
  } in_item_t;

  // Result item.
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic [FIELD_W-1:0] found_field;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic q_read;
    logic q_eval;
    logic out_pop;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic out_valid;
  } sts_t;

  // Position counter step that saturates at its top value.
  function automatic logic [POS_W-1:0] bump(input logic [POS_W-1:0] pos);
    bump = (pos == POS_LIMIT) ? pos : pos + 1'b1;
  endfunction

endpackage

>>> rtl/pbkm_ctrl.sv
module pbkm_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  input  logic             in_action_i,
  output logic             in_stall_o,
  input  logic             out_stall_i,
  input  pbkm_pkg::sts_t   sts_i,
  output pbkm_pkg::cmd_t   cmd_o
);

  pbkm_pkg::ctrl_state_e state_q, state_d;
  logic out_blocked;
  logic accept;

  // A result that waits and is stalled holds back any new result.
  assign out_blocked = sts_i.out_valid && out_stall_i;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pbkm_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state: a query byte waits in the compare state for its name row.
  always_comb begin
    state_d = state_q;
    case (state_q)
      pbkm_pkg::CS_IDLE: begin
        if (cmd_o.q_read) begin
          state_d = pbkm_pkg::CS_COMPARE;
        end
      end
      pbkm_pkg::CS_COMPARE: begin
        if (!out_blocked) begin
          state_d = pbkm_pkg::CS_IDLE;
        end
      end
      default: begin
        state_d = pbkm_pkg::CS_IDLE;
      end
    endcase
  end

  // Handshake and datapath commands.
  always_comb begin
    in_stall_o     = 1'b1;
    cmd_o          = '0;
    cmd_o.out_pop  = sts_i.out_valid && !out_stall_i;
    accept         = 1'b0;
    case (state_q)
      pbkm_pkg::CS_IDLE: begin
        in_stall_o   = out_blocked;
        accept       = in_valid_i && !out_blocked;
        cmd_o.load   = accept && (in_action_i == pbkm_pkg::ACT_LOAD);
        cmd_o.q_read = accept && (in_action_i == pbkm_pkg::ACT_QUERY);
      end
      pbkm_pkg::CS_COMPARE: begin
        cmd_o.q_eval = !out_blocked;
      end
      default: begin
        in_stall_o = 1'b1;
      end
    endcase
  end

endmodule

>>> rtl/pbkm_datapath.sv
module pbkm_datapath #(
  parameter int unsigned ENTRY_SLOTS  = pbkm_pkg::ENTRY_SLOTS_DEF,
  parameter int unsigned MAX_NAME_LEN = pbkm_pkg::MAX_NAME_LEN_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  pbkm_pkg::cmd_t      cmd_i,
  input  pbkm_pkg::in_item_t  in_item_i,
  output pbkm_pkg::sts_t      sts_o,
  output logic                out_valid_o,
  output pbkm_pkg::out_item_t out_item_o
);

  localparam int unsigned BW      = pbkm_pkg::BYTE_W;
  localparam int unsigned PW      = pbkm_pkg::POS_W;
  localparam int unsigned FW      = pbkm_pkg::FIELD_W;
  localparam int unsigned SLOT_IW = (ENTRY_SLOTS > 1) ? $clog2(ENTRY_SLOTS) : 1;
  localparam int unsigned SLOT_CW = $clog2(ENTRY_SLOTS + 1);
  localparam int unsigned ADDR_W  = $clog2(MAX_NAME_LEN);
  localparam int unsigned ROW_W   = ENTRY_SLOTS * BW;
  localparam logic [PW-1:0]      MaxLen   = PW'(MAX_NAME_LEN);
  localparam logic [SLOT_CW-1:0] SlotsAll = SLOT_CW'(ENTRY_SLOTS);

  // Name memory: one row per position, one byte lane per slot. A slot's bit
  // in the per-position match mask equals "this lane holds the byte and
  // the name reaches this position", so one row read gives every slot's
  // answer for a key byte, inside the prefix and past it alike.
  logic [ROW_W-1:0] name_mem [MAX_NAME_LEN];
  logic [ROW_W-1:0] row_q;

  logic [PW-1:0]          entry_len_q   [ENTRY_SLOTS];
  logic [FW-1:0]          entry_field_q [ENTRY_SLOTS];
  logic [ENTRY_SLOTS-1:0] entry_valid_q, entry_valid_d;
  logic [ENTRY_SLOTS-1:0] cand_q, cand_d;
  logic [SLOT_CW-1:0]     loaded_q, loaded_d;
  logic [PW-1:0]          load_pos_q, load_pos_d;
  logic [PW-1:0]          query_pos_q, query_pos_d;
  logic [BW-1:0]          qbyte_q;
  logic                   qlast_q;
  logic                   out_valid_q, out_valid_d;
  pbkm_pkg::out_item_t    out_item_q, out_item_d;

  logic                   slot_full;
  logic [SLOT_IW-1:0]     slot_idx;
  logic                   load_in_range;
  logic                   mem_we;
  logic                   entry_we;
  logic [PW-1:0]          entry_len_wr;
  logic [ENTRY_SLOTS-1:0] cur;
  logic [PW:0]            qlen;
  logic                   hit;
  logic [FW-1:0]          hit_field;

  assign slot_full     = loaded_q >= SlotsAll;
  assign slot_idx      = loaded_q[SLOT_IW-1:0];
  assign load_in_range = load_pos_q < MaxLen;
  assign mem_we        = cmd_i.load && !slot_full && load_in_range;
  assign entry_we      = cmd_i.load && !slot_full && in_item_i.last;
  assign entry_len_wr  = load_in_range ? (load_pos_q + 1'b1) : '0;

  // Name memory write (one byte lane) and registered row read.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      name_mem[load_pos_q[ADDR_W-1:0]][slot_idx*BW +: BW] <= in_item_i.key_byte;
    end
    if (cmd_i.q_read && (query_pos_q < MaxLen)) begin
      row_q <= name_mem[query_pos_q[ADDR_W-1:0]];
    end
  end

  // Query byte held for the compare cycle.
  always_ff @(posedge clk_i) begin
    if (cmd_i.q_read) begin
      qbyte_q <= in_item_i.key_byte;
      qlast_q <= in_item_i.last;
    end
  end

  // Field numbers are stored with the last byte of a name.
  always_ff @(posedge clk_i) begin
    if (entry_we && load_in_range) begin
      entry_field_q[slot_idx] <= in_item_i.field_number;
    end
  end

  // Entry lengths: zero after reset, written with the last byte of a name.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int s = 0; s < ENTRY_SLOTS; s++) begin
        entry_len_q[s] <= '0;
      end
    end else if (entry_we) begin
      entry_len_q[slot_idx] <= entry_len_wr;
    end
  end

  // Surviving candidates after this key byte.
  always_comb begin
    cur = '0;
    for (int s = 0; s < ENTRY_SLOTS; s++) begin
      cur[s] = cand_q[s] && entry_valid_q[s] && (query_pos_q < entry_len_q[s]) &&
               (row_q[s*BW +: BW] == qbyte_q);
    end
    if (query_pos_q >= MaxLen) begin
      cur = '0;
    end
  end

  // Lowest surviving slot whose length equals the key length.
  assign qlen = {1'b0, query_pos_q} + 1'b1;

  always_comb begin
    hit       = 1'b0;
    hit_field = '0;
    for (int s = ENTRY_SLOTS - 1; s >= 0; s--) begin
      if (cur[s] && ({1'b0, entry_len_q[s]} == qlen)) begin
        hit       = 1'b1;
        hit_field = entry_field_q[s];
      end
    end
  end

  // Next values of the counters, masks and the result register.
  always_comb begin
    entry_valid_d = entry_valid_q;
    cand_d        = cand_q;
    loaded_d      = loaded_q;
    load_pos_d    = load_pos_q;
    query_pos_d   = query_pos_q;
    out_valid_d   = out_valid_q && !cmd_i.out_pop;
    out_item_d    = out_item_q;

    if (cmd_i.load) begin
      if (slot_full) begin
        if (in_item_i.last) begin
          load_pos_d             = '0;
          out_valid_d            = 1'b1;
          out_item_d.status      = pbkm_pkg::ST_FULL;
          out_item_d.found_field = '0;
        end
      end else if (!in_item_i.last) begin
        load_pos_d = pbkm_pkg::bump(load_pos_q);
      end else begin
        load_pos_d             = '0;
        loaded_d               = SLOT_CW'(loaded_q + 1'b1);
        out_valid_d            = 1'b1;
        out_item_d.found_field = '0;
        if (load_in_range) begin
          entry_valid_d[slot_idx] = 1'b1;
          out_item_d.status       = pbkm_pkg::ST_OK;
        end else begin
          out_item_d.status = pbkm_pkg::ST_TOO_LONG;
        end
      end
    end

    if (cmd_i.q_eval) begin
      if (!qlast_q) begin
        cand_d      = cur;
        query_pos_d = pbkm_pkg::bump(query_pos_q);
      end else begin
        cand_d      = '1;
        query_pos_d = '0;
        out_valid_d = 1'b1;
        if (hit) begin
          out_item_d.status      = pbkm_pkg::ST_OK;
          out_item_d.found_field = hit_field;
        end else begin
          out_item_d.status      = pbkm_pkg::ST_MISS;
          out_item_d.found_field = '0;
        end
      end
    end
  end

  // Control state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_valid_q <= '0;
      cand_q        <= '1;
      loaded_q      <= '0;
      load_pos_q    <= '0;
      query_pos_q   <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      entry_valid_q <= entry_valid_d;
      cand_q        <= cand_d;
      loaded_q      <= loaded_d;
      load_pos_q    <= load_pos_d;
      query_pos_q   <= query_pos_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Result payload.
  always_ff @(posedge clk_i) begin
    out_item_q <= out_item_d;
  end

  assign sts_o.out_valid = out_valid_q;
  assign out_valid_o     = out_valid_q;
  assign out_item_o      = out_item_q;

endmodule

>>> rtl/prefix_bitmap_key_matcher.sv
// Channel | Direction | Handshake                 | Payload
// in      | input     | in_valid_i / in_stall_o   | in_item_i  (pbkm_pkg::in_item_t)
// out     | output    | out_valid_o / out_stall_i | out_item_o (pbkm_pkg::out_item_t)
//
// A query byte's name memory row is read and registered before the lane
// compares, one per slot, and the priority pick. A result appears in the
// output register in the cycle after its last byte's work.
// Reset clears counters, lengths and valid bits and sets the candidate mask
// at once; no clearing pass. Input is stalled while a query byte is compared
// and while a waiting result is itself stalled.
module prefix_bitmap_key_matcher #(
  parameter int unsigned ENTRY_SLOTS  = pbkm_pkg::ENTRY_SLOTS_DEF,
  parameter int unsigned MAX_NAME_LEN = pbkm_pkg::MAX_NAME_LEN_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  pbkm_pkg::in_item_t  in_item_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output pbkm_pkg::out_item_t out_item_o
);

  pbkm_pkg::cmd_t cmd;
  pbkm_pkg::sts_t sts;

  // Sequencer for the handshakes and the query compare cycle.
  pbkm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_action_i (in_item_i.action),
    .in_stall_o  (in_stall_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  // Name table, match logic and result register.
  pbkm_datapath #(
    .ENTRY_SLOTS  (ENTRY_SLOTS),
    .MAX_NAME_LEN (MAX_NAME_LEN)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_item_i   (in_item_i),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

>>> rtl/pbkm_checker.sv
`include "prefix_bitmap_key_matcher_defines.svh"

module pbkm_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                in_valid_i,
  input logic                in_stall_o,
  input pbkm_pkg::in_item_t  in_item_i,
  input logic                out_valid_o,
  input logic                out_stall_i,
  input pbkm_pkg::out_item_t out_item_o
);

  logic in_acc;
  logic last_acc;
  logic query_acc;
  logic no_hit;

  assign in_acc    = in_valid_i && !in_stall_o;
  assign last_acc  = in_acc && in_item_i.last;
  assign query_acc = in_acc && (in_item_i.action == pbkm_pkg::ACT_QUERY);
  assign no_hit    = out_valid_o && (out_item_o.status != pbkm_pkg::ST_OK);

  // A new result follows an accepted last byte.
  `PBKM_ASSERT_IMP(a_result_after_last, $rose(out_valid_o), $past(last_acc) || $past(last_acc, 2))

  // Only a hit carries a field number.
  `PBKM_ASSERT_IMP(a_field_zero_unless_hit, no_hit, out_item_o.found_field == '0)

  // A query byte holds the input off during its compare cycle.
  `PBKM_ASSERT_NEXT(a_query_blocks_input, query_acc, in_stall_o)

  // A stalled result stays and does not change.
  `PBKM_ASSERT_NEXT(a_out_hold, out_valid_o && out_stall_i, out_valid_o && $stable(out_item_o))

endmodule

bind prefix_bitmap_key_matcher pbkm_checker u_pbkm_checker (.*);

>>> tb/sv/key_match_checker.sv
`timescale 1ns / 100ps

module key_match_checker #(
  parameter int unsigned SLOTS    = pbkm_pkg::ENTRY_SLOTS_DEF,
  parameter int unsigned NAME_MAX = pbkm_pkg::MAX_NAME_LEN_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_stall_i,
  input  pbkm_pkg::in_item_t  in_item_i,
  input  logic                out_valid_i,
  input  logic                out_stall_i,
  input  pbkm_pkg::out_item_t out_item_i,
  output int unsigned         fail_count_o,
  output int unsigned         pending_o
);
  import pbkm_pkg::*;

  // Only the first eight positions of a name are indexed by the bitmap.
  localparam int unsigned PREFIX_BYTES = 8;

  // Local copy of the name tables.
  logic [SLOTS-1:0]   prefix_map [PREFIX_BYTES*256];
  logic [BYTE_W-1:0]  name_mem   [SLOTS*NAME_MAX];
  logic [POS_W-1:0]   slot_len   [SLOTS];
  logic [FIELD_W-1:0] name_field [SLOTS];
  logic [SLOTS-1:0]   slot_valid;
  int unsigned        slots_used;
  logic [POS_W-1:0]   load_pos;
  logic [POS_W-1:0]   query_pos;
  logic [SLOTS-1:0]   survivors;

  out_item_t due_results [$];
  out_item_t oldest_due;
  out_item_t fresh_result;

  // Position counters stop at their top value.
  function automatic logic [POS_W-1:0] next_pos(input logic [POS_W-1:0] pos);
    next_pos = (pos < POS_LIMIT) ? pos + 1'b1 : pos;
  endfunction

  function automatic void clear_tables();
    for (int unsigned i = 0; i < PREFIX_BYTES*256; i++) prefix_map[i] = '0;
    for (int unsigned i = 0; i < SLOTS*NAME_MAX; i++) name_mem[i] = '0;
    for (int unsigned i = 0; i < SLOTS; i++) begin
      slot_len[i]   = '0;
      name_field[i] = '0;
    end
    slot_valid = '0;
    slots_used = 0;
    load_pos   = '0;
    query_pos  = '0;
    survivors  = '1;
  endfunction

  // Applies one item to the tables; returns 1 when the item yields a result.
  function automatic bit match_step(input in_item_t it, output out_item_t res);
    logic [POS_W-1:0] pos;
    logic [SLOTS-1:0] live;
    int unsigned slot;
    res = '0;
    if (it.action == ACT_LOAD) begin
      pos  = load_pos;
      slot = slots_used;
      // Once every slot is taken, only the closing byte answers.
      if (slot >= SLOTS) begin
        if (!it.last) return 1'b0;
        load_pos   = '0;
        res.status = ST_FULL;
        return 1'b1;
      end
      if (pos < NAME_MAX) begin
        name_mem[slot*NAME_MAX + pos] = it.key_byte;
        if (pos < PREFIX_BYTES) prefix_map[pos*256 + it.key_byte][slot] = 1'b1;
      end
      if (!it.last) begin
        load_pos = next_pos(pos);
        return 1'b0;
      end
      load_pos   = '0;
      slots_used = slot + 1;
      // An over-long name uses up its slot but never becomes valid.
      if (pos >= NAME_MAX) begin
        slot_len[slot] = '0;
        res.status     = ST_TOO_LONG;
        return 1'b1;
      end
      slot_len[slot]   = pos + 1'b1;
      name_field[slot] = it.field_number;
      slot_valid[slot] = 1'b1;
      res.status       = ST_OK;
      return 1'b1;
    end

    // Query byte: narrow the surviving slots.
    pos  = query_pos;
    live = survivors & slot_valid;
    if (pos >= NAME_MAX) begin
      live = '0;
    end else if (pos < PREFIX_BYTES) begin
      live &= prefix_map[pos*256 + it.key_byte];
    end else begin
      for (int unsigned s = 0; s < SLOTS; s++) begin
        if (live[s] && (pos >= slot_len[s] || name_mem[s*NAME_MAX + pos] != it.key_byte))
          live[s] = 1'b0;
      end
    end
    if (!it.last) begin
      survivors = live;
      query_pos = next_pos(pos);
      return 1'b0;
    end
    survivors = '1;
    query_pos = '0;
    // The lowest surviving slot of the right length wins.
    for (int unsigned s = 0; s < SLOTS; s++) begin
      if (live[s] && slot_len[s] == pos + 1) begin
        res.status      = ST_OK;
        res.found_field = name_field[s];
        return 1'b1;
      end
    end
    res.status = ST_MISS;
    return 1'b1;
  endfunction

  // Compare accepted results first, then predict from the accepted item.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_tables();
      due_results.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (due_results.size() == 0) begin
          $error("unexpected result item: status %0d found_field %0d",
                 out_item_i.status, out_item_i.found_field);
          fail_count_o++;
        end else begin
          oldest_due = due_results.pop_front();
          if (out_item_i.status !== oldest_due.status) begin
            $error("status: expected %0d, got %0d", oldest_due.status, out_item_i.status);
            fail_count_o++;
          end
          if (out_item_i.found_field !== oldest_due.found_field) begin
            $error("found_field: expected %0d, got %0d",
                   oldest_due.found_field, out_item_i.found_field);
            fail_count_o++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) begin
        if (match_step(in_item_i, fresh_result)) due_results.push_back(fresh_result);
      end
      pending_o = due_results.size();
    end
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import pbkm_pkg::*;

  localparam int unsigned SLOTS        = ENTRY_SLOTS_DEF;
  localparam int unsigned NAME_MAX     = MAX_NAME_LEN_DEF;
  localparam int unsigned BOOK_BYTES   = 140;
  localparam int unsigned RANDOM_ITEMS = 1500;
  localparam int unsigned QUIET_LIMIT  = 3000;
  localparam int unsigned HOLD_AT      = 500;
  localparam int unsigned HOLD_CYCLES  = 250;

  logic      clk_i = 1'b0;
  logic      rst_ni;
  logic      in_valid_i;
  logic      in_stall_o;
  in_item_t  in_item_i;
  logic      out_valid_o;
  logic      out_stall_i;
  out_item_t out_item_o;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned quiet_cycles = 0;
  int unsigned counted_items;
  bit          calm_input;
  bit          loads_ignored;

  // Names loaded so far, kept so that queries can hit them.
  logic [7:0]  book [SLOTS][BOOK_BYTES];
  int unsigned book_len [SLOTS];
  int unsigned book_used;
  logic [7:0]  name_q [$];
  logic [7:0]  key_q [$];

  prefix_bitmap_key_matcher dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

  key_match_checker #(
    .SLOTS    (SLOTS),
    .NAME_MAX (NAME_MAX)
  ) u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_item_i    (in_item_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_item_i   (out_item_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Sender gaps: mostly none or short, now and then a long one.
  function automatic int unsigned idle_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (calm_input || r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_item(input logic act, input logic [7:0] b, input logic lst,
                           input logic [15:0] fld);
    in_item_t    it;
    int unsigned gap;
    it.action       = act;
    it.key_byte     = b;
    it.last         = lst;
    it.field_number = fld;
    gap = idle_gap();
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_item_i  <= it;
    in_valid_i <= 1'b1;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (act == ACT_QUERY || !loads_ignored) counted_items++;
  endtask

  // Records the name in the book while slots remain.
  task automatic record_name();
    loads_ignored = (book_used >= SLOTS);
    if (!loads_ignored) begin
      book_len[book_used] = name_q.size();
      for (int unsigned i = 0; i < name_q.size(); i++) book[book_used][i] = name_q[i];
      book_used++;
    end
  endtask

  task automatic send_name(input logic [15:0] fld);
    int unsigned n;
    record_name();
    n = name_q.size();
    for (int unsigned i = 0; i < n; i++)
      send_item(ACT_LOAD, name_q[i], i == n - 1, (i == n - 1) ? fld : 16'($urandom));
  endtask

  task automatic send_key();
    int unsigned n;
    n = key_q.size();
    for (int unsigned i = 0; i < n; i++)
      send_item(ACT_QUERY, key_q[i], i == n - 1, 16'($urandom));
  endtask

  // A load and a query whose bytes are interleaved at random.
  task automatic send_mixed(input logic [15:0] fld);
    int unsigned i;
    int unsigned j;
    int unsigned nl;
    int unsigned nk;
    record_name();
    i  = 0;
    j  = 0;
    nl = name_q.size();
    nk = key_q.size();
    while (i < nl || j < nk) begin
      if (j >= nk || (i < nl && $urandom_range(0, 1) == 1)) begin
        send_item(ACT_LOAD, name_q[i], i == nl - 1, (i == nl - 1) ? fld : 16'($urandom));
        i++;
      end else begin
        send_item(ACT_QUERY, key_q[j], j == nk - 1, 16'($urandom));
        j++;
      end
    end
  endtask

  task automatic random_name(input int unsigned len);
    name_q.delete();
    repeat (len) name_q.push_back(8'($urandom));
  endtask

  task automatic random_key(input int unsigned len);
    key_q.delete();
    repeat (len) key_q.push_back(8'($urandom));
  endtask

  task automatic key_from_book(input int unsigned idx);
    key_q.delete();
    for (int unsigned i = 0; i < book_len[idx]; i++) key_q.push_back(book[idx][i]);
  endtask

  // Result side: random stalls, free-running stretches and one long hold-off.
  initial begin : receiver
    int unsigned run_cycles;
    int unsigned seg;
    int unsigned span;
    int unsigned odds;
    bit          held;
    out_stall_i = 1'b0;
    run_cycles  = 0;
    held        = 1'b0;
    @(posedge rst_ni);
    forever begin
      seg = $urandom_range(0, 99);
      if (!held && run_cycles >= HOLD_AT) begin
        held = 1'b1;
        span = HOLD_CYCLES;
        odds = 100;
      end else if (seg < 25) begin
        span = $urandom_range(20, 80);
        odds = 0;
      end else if (seg < 27) begin
        span = $urandom_range(20, 120);
        odds = 100;
      end else if (seg < 60) begin
        span = $urandom_range(10, 50);
        odds = 10;
      end else begin
        span = $urandom_range(10, 50);
        odds = 40;
      end
      repeat (span) begin
        @(posedge clk_i);
        out_stall_i <= ($urandom_range(0, 99) < odds);
        run_cycles++;
      end
    end
  end

  // Ends the run when neither channel has moved for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned pos;
    int unsigned len;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    in_item_i     = '0;
    calm_input    = 1'b0;
    loads_ignored = 1'b0;
    book_used     = 0;
    counted_items = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Single-byte name with the top field number, then a hit, a wrong byte
    // and a key one byte too long.
    name_q = '{8'h00};
    send_name(16'hFFFF);
    key_q = '{8'h00};
    send_key();
    key_q = '{8'hFF};
    send_key();
    key_q = '{8'h00, 8'h00};
    send_key();

    // Two names sharing a prefix longer than the bitmap covers.
    random_name(12);
    name_q[0] = 8'hFF;
    send_name(16'h0000);
    name_q[10] = name_q[10] ^ 8'h5A;
    send_name(16'($urandom));
    key_from_book(1);
    send_key();
    key_from_book(2);
    send_key();
    key_from_book(1);
    key_q[11] = key_q[11] ^ 8'h81;
    send_key();
    key_from_book(1);
    key_q = key_q[0:9];
    send_key();

    // A name far over the limit saturates the load position and is refused.
    random_name(130);
    send_name(16'($urandom));
    key_from_book(3);
    send_key();

    // A name of exactly the limit, then keys one over and far over it.
    random_name(NAME_MAX);
    send_name(16'($urandom));
    key_from_book(4);
    send_key();
    key_q.push_back(8'($urandom));
    send_key();
    random_key(130);
    send_key();

    // A repeated name: the lower slot keeps answering.
    key_from_book(1);
    name_q = key_q;
    send_name(16'($urandom));
    send_key();

    // One byte over the limit.
    random_name(NAME_MAX + 1);
    send_name(16'($urandom));

    // Random part: mostly keys built from stored names, with some noise.
    counted_items = 0;
    while (counted_items < RANDOM_ITEMS) begin
      calm_input = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        key_from_book($urandom_range(0, book_used - 1));
        send_key();
      end else if (pick < 57) begin
        key_from_book($urandom_range(0, book_used - 1));
        pos = $urandom_range(0, key_q.size() - 1);
        key_q[pos] = key_q[pos] ^ 8'($urandom_range(1, 255));
        send_key();
      end else if (pick < 65) begin
        key_from_book($urandom_range(0, book_used - 1));
        if (key_q.size() > 1 && $urandom_range(0, 1) == 1) void'(key_q.pop_back());
        else key_q.push_back(8'($urandom));
        send_key();
      end else if (pick < 75) begin
        random_key($urandom_range(1, 12));
        send_key();
      end else if (pick < 80) begin
        random_key($urandom_range(NAME_MAX + 1, BOOK_BYTES));
        send_key();
      end else if (pick < 88) begin
        len = ($urandom_range(0, 3) == 0) ? $urandom_range(1, BOOK_BYTES)
                                           : $urandom_range(1, 20);
        random_name(len);
        send_name(16'($urandom));
      end else if (pick < 95) begin
        random_name($urandom_range(1, 16));
        key_from_book($urandom_range(0, book_used - 1));
        send_mixed(16'($urandom));
      end else begin
        random_key($urandom_range(1, 3));
        send_key();
      end
    end
    in_valid_i <= 1'b0;

    // Drain the outstanding results, then allow for the pipeline depth.
    while (pending != 0) @(negedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
